FILE: src/bmvd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and fp32 arithmetic functions for the bf16 matrix-vector dot core.
// No dependencies.
package bmvd_pkg;

	localparam int ROW_LENGTH_DEF = 32;
	localparam int RPC_W = 13;
	localparam int BASE_W = 12;
	localparam int ROWCNT_W = 12;
	localparam int CFG_W = 13;
	localparam logic [RPC_W-1:0] RPC_MAX = 13'd4096;

	typedef enum logic {
		REG_ROWS_PER_CALL = 1'b0,
		REG_ROW_BASE      = 1'b1
	} cfg_reg_t;

	localparam logic [31:0] FP32_QNAN = 32'h7FC00000;
	localparam logic [15:0] BF16_QNAN = 16'h7FC0;

	function automatic logic [4:0] clz27(logic [26:0] v);
		logic [4:0] n;
		n = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) n = 5'(26 - i);
		end
		return n;
	endfunction

	// round nearest-even and pack; sig has its leading one at bit 26
	function automatic logic [31:0] round_pack(logic s, logic signed [10:0] e, logic [26:0] sig);
		logic [26:0] sg;
		logic [10:0] sh;
		logic [7:0] ef;
		logic inc;
		logic [31:0] r;
		sg = sig;
		ef = 8'd0;
		if (e >= 11'sd255) begin
			return {s, 8'hFF, 23'd0};
		end
		if (e <= 11'sd0) begin
			sh = 11'(11'sd1 - e);
			if (sh >= 11'd27) begin
				sg = {26'd0, |sig};
			end else begin
				sg = (sig >> sh) | {26'd0, |(sig & ~({27{1'b1}} << sh))};
			end
		end else begin
			ef = e[7:0];
		end
		inc = sg[2] & (sg[3] | sg[1] | sg[0]);
		r = {s, ef, sg[25:3]} + {31'd0, inc};
		return r;
	endfunction

	function automatic logic [31:0] fp32_add(logic [31:0] x, logic [31:0] y);
		logic xnan, ynan, xinf, yinf;
		logic [31:0] big, sml;
		logic [7:0] eb, es, d;
		logic [26:0] sb, ss0, ss;
		logic [27:0] sum;
		logic [26:0] sig;
		logic [4:0] lz;
		logic signed [10:0] e;
		xnan = (&x[30:23]) && (|x[22:0]);
		ynan = (&y[30:23]) && (|y[22:0]);
		xinf = (&x[30:23]) && !(|x[22:0]);
		yinf = (&y[30:23]) && !(|y[22:0]);
		if (xnan || ynan || (xinf && yinf && (x[31] != y[31]))) return FP32_QNAN;
		if (xinf) return x;
		if (yinf) return y;
		if (x[30:0] >= y[30:0]) begin
			big = x;
			sml = y;
		end else begin
			big = y;
			sml = x;
		end
		eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		d = eb - es;
		sb = {(big[30:23] != 8'd0), big[22:0], 3'b000};
		ss0 = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
		if (d >= 8'd27) begin
			ss = {26'd0, |ss0};
		end else begin
			ss = (ss0 >> d) | {26'd0, |(ss0 & ~({27{1'b1}} << d))};
		end
		if (x[31] == y[31]) sum = {1'b0, sb} + {1'b0, ss};
		else sum = {1'b0, sb} - {1'b0, ss};
		if (sum == 28'd0) return {x[31] & y[31], 31'd0};
		if (sum[27]) begin
			sig = {sum[27:2], sum[1] | sum[0]};
			e = 11'(eb) + 11'sd1;
		end else begin
			lz = clz27(sum[26:0]);
			sig = sum[26:0] << lz;
			e = 11'(eb) - 11'(lz);
		end
		return round_pack(big[31], e, sig);
	endfunction

	function automatic logic [15:0] fp32_to_bf16(logic [31:0] w);
		logic [31:0] t;
		if ((&w[30:23]) && (|w[22:0])) return BF16_QNAN;
		t = w + 32'h00007FFF + {31'd0, w[16]};
		return t[31:16];
	endfunction

endpackage

FILE: src/bmvd_fmul.sv
`timescale 1ns / 1ps
// Exact bf16 x bf16 product rounded into fp32 (subnormals kept).
// Depends on bmvd_pkg.
module bmvd_fmul (
	input  logic [15:0] a,
	input  logic [15:0] b,
	output logic [31:0] p
);
	import bmvd_pkg::*;

	logic anan, bnan, ainf, binf, azero, bzero;
	logic s;
	logic [7:0] ma, mb;
	logic [15:0] prod;
	logic [4:0] lz;
	logic [26:0] sig;
	logic signed [10:0] e;

	always_comb begin
		anan = (&a[14:7]) && (|a[6:0]);
		bnan = (&b[14:7]) && (|b[6:0]);
		ainf = (&a[14:7]) && !(|a[6:0]);
		binf = (&b[14:7]) && !(|b[6:0]);
		azero = (a[14:0] == 15'd0);
		bzero = (b[14:0] == 15'd0);
		s = a[15] ^ b[15];
		ma = {(a[14:7] != 8'd0), a[6:0]};
		mb = {(b[14:7] != 8'd0), b[6:0]};
		prod = ma * mb;
		lz = clz27({prod, 11'd0});
		sig = {prod, 11'd0} << lz;
		e = 11'((a[14:7] == 8'd0) ? 8'd1 : a[14:7]) + 11'((b[14:7] == 8'd0) ? 8'd1 : b[14:7])
			- 11'sd126 - 11'(lz);
		if (anan || bnan || (ainf && bzero) || (binf && azero)) begin
			p = FP32_QNAN;
		end else if (ainf || binf) begin
			p = {s, 8'hFF, 23'd0};
		end else if (azero || bzero) begin
			p = {s, 31'd0};
		end else begin
			p = round_pack(s, e, sig);
		end
	end
endmodule

FILE: src/bf16_matrix_vector_dot_core.sv
`timescale 1ns / 1ps
// Top level: bf16 matrix-vector dot product with fp32 accumulation.
// Depends on bmvd_pkg and bmvd_fmul.
//
// channel | signals                                    | role
// in      | in_valid, in_ready, matrix_value, vector_value | one element pair per request
// out     | out_valid, out_ready, sum_value, row_index, call_last | one row result
// cfg     | cfg_we, cfg_index, cfg_data                | register write, no wait
//
// One request per cycle while in_ready is high. Operands, product and row result
// have a register; the fp32 accumulate loop is one register, sum_q.
// Input stalls only when a row-ending request reaches the accumulator while the
// output register still holds an untaken result. Reset clears counts and the sum.
module bf16_matrix_vector_dot_core #(
	parameter int ROW_LENGTH = bmvd_pkg::ROW_LENGTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [15:0]                matrix_value,
	input  logic [15:0]                vector_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [15:0]                sum_value,
	output logic [12:0]                row_index,
	output logic                       call_last,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [bmvd_pkg::CFG_W-1:0] cfg_data
);
	import bmvd_pkg::*;

	localparam int CW = (ROW_LENGTH > 1) ? $clog2(ROW_LENGTH) : 1;

	logic [CW-1:0] cnt_q;
	logic [RPC_W-1:0] rpc_q;
	logic [BASE_W-1:0] base_q;
	logic [ROWCNT_W-1:0] row_cnt_q;
	logic [31:0] sum_q;

	logic [15:0] a_s1, b_s1;
	logic v_s1, end_s1;
	logic [31:0] prod_s2;
	logic v_s2, end_s2;
	logic [31:0] prod;

	logic blk, adv, in_end, last;
	logic [31:0] acc;
	logic [RPC_W-1:0] eff;

	bmvd_fmul u_fmul (
		.a(a_s1),
		.b(b_s1),
		.p(prod)
	);

	always_comb begin
		blk = v_s2 && end_s2 && out_valid && !out_ready;
		adv = !blk;
		in_ready = adv;
		in_end = (cnt_q == CW'(ROW_LENGTH - 1));
		acc = fp32_add(sum_q, prod_s2);
		if (rpc_q == '0) eff = RPC_W'(1);
		else if (rpc_q > RPC_MAX) eff = RPC_MAX;
		else eff = rpc_q;
		last = ({1'b0, row_cnt_q} + 13'd1) >= eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpc_q <= RPC_W'(1);
			base_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROWS_PER_CALL: rpc_q <= cfg_data[RPC_W-1:0];
				REG_ROW_BASE:      base_q <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1 <= 1'b0;
			end_s1 <= 1'b0;
			v_s2 <= 1'b0;
			end_s2 <= 1'b0;
			sum_q <= '0;
			row_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			out_valid <= (out_valid && !out_ready) || (adv && v_s2 && end_s2);
			if (adv) begin
				v_s1 <= in_valid;
				end_s1 <= in_end;
				if (in_valid) cnt_q <= in_end ? '0 : cnt_q + CW'(1);
				v_s2 <= v_s1;
				end_s2 <= end_s1;
				if (v_s2) begin
					if (end_s2) begin
						sum_q <= '0;
						row_cnt_q <= last ? '0 : row_cnt_q + ROWCNT_W'(1);
					end else begin
						sum_q <= acc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= matrix_value;
			b_s1 <= vector_value;
			prod_s2 <= prod;
			if (v_s2 && end_s2) begin
				sum_value <= fp32_to_bf16(acc);
				row_index <= 13'(base_q) + 13'(row_cnt_q);
				call_last <= last;
			end
		end
	end
endmodule

FILE: tb/bf16_matrix_vector_dot_core_tb.sv
`timescale 1ns / 1ps
// Testbench for bf16_matrix_vector_dot_core: directed rows then random rows, each checked
// against an fp32-accumulate model held here. Depends on bmvd_pkg and the core's RTL.
module bf16_matrix_vector_dot_core_tb;
	import bmvd_pkg::*;

	localparam int ROW_LEN = 32;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [15:0] sum_value;
		logic [12:0] row_index;
		logic        call_last;
	} row_result_t;

	typedef struct {
		logic [15:0] m0, v0, m1, v1;
		logic        known;
		logic [15:0] sum_lit;
	} row_case_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] matrix_value = '0;
	logic [15:0] vector_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] sum_value;
	logic [12:0] row_index;
	logic call_last;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_ROWS_PER_CALL;
	logic [CFG_W-1:0] cfg_data = '0;

	row_result_t row_results_q[$];
	int errors = 0;
	int rows_seen = 0;
	int cycles = 0;
	int next_gap = 0;

	logic [12:0] rows_per_call_m;
	logic [11:0] row_base_m;
	logic [31:0] acc_m;
	int elem_cnt_m;
	int row_cnt_m;

	bf16_matrix_vector_dot_core u_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic real f32_to_real(logic [31:0] w);
		real r;
		if (w[30:23] == 8'd0) begin
			if (w[22:0] == 23'd0) return $bitstoreal({w[31], 63'd0});
			r = real'(w[22:0]) * (2.0 ** (-149));
			return w[31] ? -r : r;
		end
		return $bitstoreal({w[31], 11'(w[30:23]) + 11'd896, w[22:0], 29'd0});
	endfunction

	function automatic logic [31:0] real_to_f32(real x);
		logic [63:0] db, m, q, rem, halfv;
		int ex, sh;
		logic inc;
		db = $realtobits(x);
		if (db[62:52] == 11'd0) return {db[63], 31'd0};
		ex = int'(db[62:52]) - 1023;
		if (ex > 127) return {db[63], 8'hFF, 23'd0};
		m = {11'd0, 1'b1, db[51:0]};
		sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
		if (sh > 54) return {db[63], 31'd0};
		q = m >> sh;
		rem = m & ((64'd1 << sh) - 64'd1);
		halfv = 64'd1 << (sh - 1);
		inc = (rem > halfv) || (rem == halfv && q[0]);
		if (ex >= -126) return {db[63], 8'(ex + 127), q[22:0]} + {31'd0, inc};
		return {db[63], 31'(q)} + {31'd0, inc};
	endfunction

	function automatic logic is_nan32(logic [31:0] w);
		return (&w[30:23]) && (|w[22:0]);
	endfunction

	function automatic logic is_inf32(logic [31:0] w);
		return (&w[30:23]) && !(|w[22:0]);
	endfunction

	function automatic logic [31:0] bf16_product(logic [15:0] a, logic [15:0] b);
		logic [31:0] x, y;
		x = {a, 16'd0};
		y = {b, 16'd0};
		if (is_nan32(x) || is_nan32(y)) return FP32_QNAN;
		if ((is_inf32(x) && y[30:0] == 0) || (is_inf32(y) && x[30:0] == 0)) return FP32_QNAN;
		if (is_inf32(x) || is_inf32(y)) return {x[31] ^ y[31], 8'hFF, 23'd0};
		return real_to_f32(f32_to_real(x) * f32_to_real(y));
	endfunction

	function automatic logic [31:0] fp32_sum(logic [31:0] x, logic [31:0] y);
		if (is_nan32(x) || is_nan32(y)) return FP32_QNAN;
		if (is_inf32(x) && is_inf32(y) && x[31] != y[31]) return FP32_QNAN;
		if (is_inf32(x)) return x;
		if (is_inf32(y)) return y;
		return real_to_f32(f32_to_real(x) + f32_to_real(y));
	endfunction

	function automatic logic [15:0] round_to_bf16(logic [31:0] w);
		logic [31:0] t;
		if (is_nan32(w)) return BF16_QNAN;
		t = w + 32'h7FFF + {31'd0, w[16]};
		return t[31:16];
	endfunction

	task automatic accumulate_pair(logic [15:0] a, logic [15:0] b);
		row_result_t r;
		int eff;
		acc_m = fp32_sum(acc_m, bf16_product(a, b));
		elem_cnt_m++;
		if (elem_cnt_m < ROW_LEN) return;
		eff = rows_per_call_m;
		if (eff == 0) eff = 1;
		if (eff > 4096) eff = 4096;
		r.sum_value = round_to_bf16(acc_m);
		r.row_index = 13'(row_base_m + row_cnt_m);
		r.call_last = (row_cnt_m + 1) >= eff;
		row_results_q.push_back(r);
		acc_m = 32'd0;
		elem_cnt_m = 0;
		row_cnt_m = r.call_last ? 0 : row_cnt_m + 1;
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 40) return 0;
		if (p < 85) return $urandom_range(3, 1);
		if (p < 97) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	task automatic send_pair(logic [15:0] a, logic [15:0] b);
		repeat (next_gap) @(posedge clk);
		in_valid <= 1'b1;
		matrix_value <= a;
		vector_value <= b;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
		accumulate_pair(a, b);
		next_gap = pick_gap();
		if (next_gap > 0) in_valid <= 1'b0;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_ROWS_PER_CALL) rows_per_call_m = val;
		else row_base_m = val[11:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		next_gap = 0;
		while (row_results_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [15:0] random_bf16();
		if ($urandom_range(99) < 15) return 16'($urandom);
		return {1'($urandom), 8'($urandom_range(134, 120)), 7'($urandom)};
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// receiver: random stalls, one long hold-off to back the core up
	initial begin
		int hold;
		int gap;
		logic hold_done;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && rows_seen >= 20) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				hold = 400;
				repeat (hold) @(posedge clk);
			end
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(negedge clk) begin
		row_result_t e;
		if (arst_n && out_valid && out_ready) begin
			rows_seen++;
			if (row_results_q.size() == 0) begin
				report_mismatch($sformatf("unexpected row result %h", sum_value));
			end else begin
				e = row_results_q.pop_front();
				if (sum_value !== e.sum_value)
					report_mismatch($sformatf("sum_value %h, want %h", sum_value, e.sum_value));
				if (row_index !== e.row_index)
					report_mismatch($sformatf("row_index %0d, want %0d", row_index, e.row_index));
				if (call_last !== e.call_last)
					report_mismatch($sformatf("call_last %b, want %b", call_last, e.call_last));
			end
		end
	end

	initial begin
		row_case_t cases[$];
		logic [12:0] rpc_set[6];
		logic [11:0] base_set[6];
		int tail;
		rows_per_call_m = 13'd1;
		row_base_m = 12'd0;
		acc_m = 32'd0;
		elem_cnt_m = 0;
		row_cnt_m = 0;
		cases = '{
			'{16'h3F80, 16'h3F80, 16'h0000, 16'h0000, 1'b1, 16'h3F80},
			'{16'h7F80, 16'h3F80, 16'h0000, 16'h0000, 1'b1, 16'h7F80},
			'{16'hFF80, 16'h3F80, 16'h0000, 16'h0000, 1'b1, 16'hFF80},
			'{16'h7F80, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h7FC0},
			'{16'h7FC1, 16'h3F80, 16'h0000, 16'h0000, 1'b1, 16'h7FC0},
			'{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 16'h7FC0},
			'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000},
			'{16'h8000, 16'h3F80, 16'h0000, 16'h0000, 1'b1, 16'h0000},
			'{16'h7F7F, 16'h7F7F, 16'h0000, 16'h0000, 1'b1, 16'h7F80},
			'{16'h0001, 16'h0001, 16'h0000, 16'h0000, 1'b1, 16'h0000},
			'{16'h7F7F, 16'h3F80, 16'h0000, 16'h0000, 1'b1, 16'h7F7F},
			'{16'h7F80, 16'h3F80, 16'hFF80, 16'h3F80, 1'b1, 16'h7FC0},
			'{16'h0080, 16'h3F00, 16'h0001, 16'h3F80, 1'b0, 16'h0000},
			'{16'h7F7F, 16'h3F80, 16'h7B80, 16'h3F80, 1'b0, 16'h0000},
			'{16'h3F81, 16'h3F81, 16'hBF80, 16'h3F80, 1'b0, 16'h0000}
		};
		rpc_set = '{13'd0, 13'd4096, 13'd8191, 13'd3, 13'd2, 13'd1};
		base_set = '{12'd4095, 12'd100, 12'd7, 12'd4095, 12'd0, 12'd0};
		rpc_set[5] = 13'($urandom_range(8191));
		base_set[5] = 12'($urandom);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (cases[c]) begin
			for (int i = 0; i < ROW_LEN; i++) begin
				if (i == 0) send_pair(cases[c].m0, cases[c].v0);
				else if (i == 1) send_pair(cases[c].m1, cases[c].v1);
				else send_pair(16'h0000, 16'h0000);
			end
			if (cases[c].known)
				row_results_q[row_results_q.size()-1].sum_value = cases[c].sum_lit;
		end

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_reg(REG_ROWS_PER_CALL, rpc_set[ph]);
			write_reg(REG_ROW_BASE, {1'b0, base_set[ph]});
			tail = (ph % 2 == 1) ? $urandom_range(ROW_LEN - 1, 1) : 0;
			repeat (5 * ROW_LEN + tail) send_pair(random_bf16(), random_bf16());
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: bf16_matrix_vector_dot_core.f
src/bmvd_pkg.sv
src/bmvd_fmul.sv
src/bf16_matrix_vector_dot_core.sv
tb/bf16_matrix_vector_dot_core_tb.sv
